// File: rtl/core/vssa_pkg.sv
// Shared types, codes and saturating arithmetic for the voice session start/stop unit.
package vssa_pkg;

  localparam int TIME_WIDTH    = 24;
  localparam int CFG_WIDTH     = 24;
  localparam int ELAPSED_WIDTH = 16;
  localparam int MODE_WIDTH    = 3;
  localparam int ACTION_WIDTH  = 2;
  localparam int CAUSE_WIDTH   = 2;
  localparam int CFG_IDX_WIDTH = 3;
  localparam int WIDE = (TIME_WIDTH > CFG_WIDTH) ? TIME_WIDTH : CFG_WIDTH;

  localparam logic [WIDE-1:0] TMAX_WIDE = WIDE'({TIME_WIDTH{1'b1}});

  // mode codes
  localparam logic [MODE_WIDTH-1:0] MODE_DISABLED = 3'd0;
  localparam logic [MODE_WIDTH-1:0] MODE_MONITOR  = 3'd1;
  localparam logic [MODE_WIDTH-1:0] MODE_CONFIRM  = 3'd2;
  localparam logic [MODE_WIDTH-1:0] MODE_RECORD   = 3'd3;
  localparam logic [MODE_WIDTH-1:0] MODE_TAIL     = 3'd4;
  localparam logic [MODE_WIDTH-1:0] MODE_COOLDOWN = 3'd5;

  // action codes
  localparam logic [ACTION_WIDTH-1:0] ACT_NONE  = 2'd0;
  localparam logic [ACTION_WIDTH-1:0] ACT_START = 2'd1;
  localparam logic [ACTION_WIDTH-1:0] ACT_STOP  = 2'd2;

  // stop causes
  localparam logic [CAUSE_WIDTH-1:0] CAUSE_NONE    = 2'd0;
  localparam logic [CAUSE_WIDTH-1:0] CAUSE_SILENCE = 2'd1;
  localparam logic [CAUSE_WIDTH-1:0] CAUSE_MAX     = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_WIDTH-1:0] REG_CONFIRM_TIME  = 3'd0;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_PREROLL_TIME  = 3'd1;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_SILENCE_LIMIT = 3'd2;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_TAIL_TIME     = 3'd3;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_MIN_SESSION   = 3'd4;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_MAX_SESSION   = 3'd5;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_COOLDOWN_TIME = 3'd6;

  typedef struct packed {
    logic                     enable;
    logic                     start_enable;
    logic                     stop_enable;
    logic                     rec_active;
    logic                     speech;
    logic                     start_block;
    logic [ELAPSED_WIDTH-1:0] elapsed;
  } tick_t;

  typedef struct packed {
    logic [MODE_WIDTH-1:0]   mode;
    logic [ACTION_WIDTH-1:0] action_code;
    logic [CAUSE_WIDTH-1:0]  stop_cause;
    logic [CFG_WIDTH-1:0]    preroll_out;
  } result_t;

  typedef struct packed {
    logic [CFG_WIDTH-1:0] confirm_time;
    logic [CFG_WIDTH-1:0] preroll_time;
    logic [CFG_WIDTH-1:0] silence_limit;
    logic [CFG_WIDTH-1:0] tail_time;
    logic [CFG_WIDTH-1:0] min_session;
    logic [CFG_WIDTH-1:0] max_session;
    logic [CFG_WIDTH-1:0] cooldown_time;
  } cfg_regs_t;

  typedef struct packed {
    logic [MODE_WIDTH-1:0] mode;
    logic [TIME_WIDTH-1:0] rec_count;
    logic [TIME_WIDTH-1:0] silence_count;
    logic [TIME_WIDTH-1:0] speech_count;
    logic [TIME_WIDTH-1:0] cooldown_left;
  } sess_state_t;

  // Add and clamp at the top of the time width.
  function automatic logic [WIDE-1:0] sat_add(input logic [WIDE-1:0] a,
                                              input logic [WIDE-1:0] b);
    logic [WIDE:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s > {1'b0, TMAX_WIDE}) begin
      return TMAX_WIDE;
    end
    return s[WIDE-1:0];
  endfunction

endpackage

// File: rtl/core/vssa_tick_if.sv
// Tick request channel: valid/ready with one tick of flags and elapsed time.
interface vssa_tick_if;
  logic          valid;
  logic          ready;
  vssa_pkg::tick_t data;

  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

// File: rtl/core/vssa_result_if.sv
// Result request channel: valid/ready with mode, action and pre-roll.
interface vssa_result_if;
  logic            valid;
  logic            ready;
  vssa_pkg::result_t data;

  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

// File: rtl/core/vssa_cfg_if.sv
// Configuration write channel: valid/ready with register index and write data.
interface vssa_cfg_if;
  logic                                 valid;
  logic                                 ready;
  logic [vssa_pkg::CFG_IDX_WIDTH-1:0]   index;
  logic [vssa_pkg::CFG_WIDTH-1:0]       data;

  modport source(output valid, output index, output data, input ready);
  modport sink(input valid, input index, input data, output ready);
endinterface

// File: rtl/core/vssa_step.sv
// Next-state and result logic for one tick of the session controller.
module vssa_step (
  input  vssa_pkg::cfg_regs_t   cfg_regs,
  input  vssa_pkg::sess_state_t cur,
  input  vssa_pkg::tick_t       item,
  output vssa_pkg::sess_state_t nxt,
  output vssa_pkg::result_t     res
);
  import vssa_pkg::*;

  always_comb begin
    logic [MODE_WIDTH-1:0]   m;
    logic [WIDE-1:0]         rc;
    logic [WIDE-1:0]         sc;
    logic [WIDE-1:0]         spc;
    logic [WIDE-1:0]         cl;
    logic [WIDE-1:0]         el;
    logic [WIDE-1:0]         cd;
    logic [ACTION_WIDTH-1:0] act;
    logic [CAUSE_WIDTH-1:0]  cause;
    logic [CFG_WIDTH-1:0]    pre;
    logic                    in_rec;
    logic                    go_on;

    m      = cur.mode;
    rc     = WIDE'(cur.rec_count);
    sc     = WIDE'(cur.silence_count);
    spc    = WIDE'(cur.speech_count);
    cl     = WIDE'(cur.cooldown_left);
    el     = WIDE'(item.elapsed);
    cd     = WIDE'(cfg_regs.cooldown_time);
    act    = ACT_NONE;
    cause  = CAUSE_NONE;
    pre    = '0;
    in_rec = (cur.mode == MODE_RECORD) || (cur.mode == MODE_TAIL);
    go_on  = 1'b1;

    if (!item.enable || (!item.start_enable && !item.stop_enable)) begin
      m   = MODE_DISABLED;
      rc  = '0;
      sc  = '0;
      spc = '0;
      cl  = '0;
    end else if (item.rec_active) begin
      if (!in_rec) begin
        rc = '0;
        sc = '0;
      end
      rc  = sat_add(rc, el);
      spc = '0;
      if (item.speech) begin
        sc = '0;
        m  = MODE_RECORD;
      end else if (item.stop_enable) begin
        sc = sat_add(sc, el);
        m  = (sc >= WIDE'(cfg_regs.silence_limit)) ? MODE_TAIL : MODE_RECORD;
      end else begin
        sc = '0;
        m  = MODE_RECORD;
      end
      // Max duration wins over silence when both hold.
      if (item.stop_enable && (cfg_regs.max_session != '0) &&
          (rc >= WIDE'(cfg_regs.max_session))) begin
        act   = ACT_STOP;
        cause = CAUSE_MAX;
      end else if (item.stop_enable && (rc >= WIDE'(cfg_regs.min_session)) &&
                   (sc >= sat_add(WIDE'(cfg_regs.silence_limit),
                                  WIDE'(cfg_regs.tail_time)))) begin
        act   = ACT_STOP;
        cause = CAUSE_SILENCE;
      end
    end else begin
      if (in_rec) begin
        m  = MODE_COOLDOWN;
        cl = (cd > TMAX_WIDE) ? TMAX_WIDE : cd;
        rc = '0;
        sc = '0;
      end
      if (m == MODE_COOLDOWN) begin
        cl = (el >= cl) ? '0 : (cl - el);
        if (cl != '0) begin
          go_on = 1'b0;
        end else begin
          m = MODE_MONITOR;
        end
      end
      if (go_on) begin
        rc = '0;
        sc = '0;
        if (!item.start_enable || item.start_block || !item.speech) begin
          spc = '0;
          m   = MODE_MONITOR;
        end else begin
          spc = sat_add(spc, el);
          m   = MODE_CONFIRM;
          if (spc >= WIDE'(cfg_regs.confirm_time)) begin
            act = ACT_START;
            pre = cfg_regs.preroll_time;
            spc = '0;
          end
        end
      end
    end

    nxt.mode          = m;
    nxt.rec_count     = rc[TIME_WIDTH-1:0];
    nxt.silence_count = sc[TIME_WIDTH-1:0];
    nxt.speech_count  = spc[TIME_WIDTH-1:0];
    nxt.cooldown_left = cl[TIME_WIDTH-1:0];

    res.mode        = m;
    res.action_code = act;
    res.stop_cause  = cause;
    res.preroll_out = pre;
  end

endmodule

// File: rtl/core/voice_session_auto_start_stop_unit.sv
// Top level of the voice session auto start/stop controller.
//
//   channel  | dir | handshake    | payload
//   ---------+-----+--------------+--------------------------------------------
//   tick     | in  | valid/ready  | enable, start/stop enable, rec_active,
//            |     |              | speech, start_block, elapsed (16 bit ms)
//   result   | out | valid/ready  | mode, action_code, stop_cause, preroll_out
//   cfg      | in  | valid/ready  | index (3 bit), data (24 bit); always ready
//
// One tick per cycle sustained while results are taken; an accepted tick goes into
// the input register, then through the step logic into the result register.
// The mode and the four counters update in the same cycle the result register
// loads, so back-to-back ticks see each other's state without a bubble.
// Reset clears the mode, the counters, both valid flags and restores the
// register defaults. A stalled result holds the pipe; the input register
// still takes a tick while it is empty or the result register is free or
// being drained.
module voice_session_auto_start_stop_unit (
  input logic        clk,
  input logic        rst,
  vssa_tick_if.sink     tick,
  vssa_result_if.source result,
  vssa_cfg_if.sink      cfg
);
  import vssa_pkg::*;

  cfg_regs_t   cfg_regs;
  sess_state_t state;
  sess_state_t state_next;
  tick_t       in_q;
  logic        in_valid;
  result_t     out_q;
  result_t     out_next;
  logic        out_valid;
  logic        advance;

  // The result register can load when empty or when its request is taken.
  assign advance      = !out_valid || result.ready;
  assign tick.ready   = !in_valid || advance;
  assign result.valid = out_valid;
  assign result.data  = out_q;
  assign cfg.ready    = 1'b1;

  // Register file; unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs.confirm_time  <= CFG_WIDTH'(200);
      cfg_regs.preroll_time  <= CFG_WIDTH'(500);
      cfg_regs.silence_limit <= CFG_WIDTH'(1500);
      cfg_regs.tail_time     <= CFG_WIDTH'(300);
      cfg_regs.min_session   <= CFG_WIDTH'(1000);
      cfg_regs.max_session   <= CFG_WIDTH'(60000);
      cfg_regs.cooldown_time <= CFG_WIDTH'(1000);
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_CONFIRM_TIME:  cfg_regs.confirm_time  <= cfg.data;
        REG_PREROLL_TIME:  cfg_regs.preroll_time  <= cfg.data;
        REG_SILENCE_LIMIT: cfg_regs.silence_limit <= cfg.data;
        REG_TAIL_TIME:     cfg_regs.tail_time     <= cfg.data;
        REG_MIN_SESSION:   cfg_regs.min_session   <= cfg.data;
        REG_MAX_SESSION:   cfg_regs.max_session   <= cfg.data;
        REG_COOLDOWN_TIME: cfg_regs.cooldown_time <= cfg.data;
        default: begin
        end
      endcase
    end
  end

  // Input register: capture a tick request whenever the stage is free.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (tick.ready) begin
      in_valid <= tick.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (tick.ready && tick.valid) begin
      in_q <= tick.data;
    end
  end

  vssa_step u_step (
    .cfg_regs (cfg_regs),
    .cur      (state),
    .item     (in_q),
    .nxt      (state_next),
    .res      (out_next)
  );

  // Advance the session state and the result register together.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid           <= 1'b0;
      state.mode          <= MODE_DISABLED;
      state.rec_count     <= '0;
      state.silence_count <= '0;
      state.speech_count  <= '0;
      state.cooldown_left <= '0;
    end else if (advance) begin
      out_valid <= in_valid;
      if (in_valid) begin
        state <= state_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_valid) begin
      out_q <= out_next;
    end
  end

endmodule

// File: rtl/core/vssa_checker.sv
// Port-level checks on results of the voice session unit, with its bind.
module vssa_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              res_valid,
  input logic                              res_ready,
  input logic [vssa_pkg::MODE_WIDTH-1:0]   res_mode,
  input logic [vssa_pkg::ACTION_WIDTH-1:0] res_action,
  input logic [vssa_pkg::CAUSE_WIDTH-1:0]  res_cause,
  input logic [vssa_pkg::CFG_WIDTH-1:0]    res_preroll
);
  import vssa_pkg::*;

  // A cause only travels with a stop.
  a_cause_with_stop: assert property (@(posedge clk) disable iff (rst)
    res_valid && (res_action != ACT_STOP) |-> (res_cause == CAUSE_NONE))
    else $error("stop cause set without a stop");

  // Pre-roll is zero unless a start is requested.
  a_preroll_with_start: assert property (@(posedge clk) disable iff (rst)
    res_valid && (res_action != ACT_START) |-> (res_preroll == '0))
    else $error("pre-roll set without a start");

  // A start request leaves the unit in confirming mode.
  a_start_mode: assert property (@(posedge clk) disable iff (rst)
    res_valid && (res_action == ACT_START) |-> (res_mode == MODE_CONFIRM))
    else $error("start outside confirming mode");

  // A stop request only comes from a recording mode.
  a_stop_mode: assert property (@(posedge clk) disable iff (rst)
    res_valid && (res_action == ACT_STOP) |->
      ((res_mode == MODE_RECORD) || (res_mode == MODE_TAIL)))
    else $error("stop outside a recording mode");

  // A stalled result request stays up.
  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid)
    else $error("result request dropped while stalled");

endmodule

bind voice_session_auto_start_stop_unit vssa_checker u_vssa_checker (
  .clk         (clk),
  .rst         (rst),
  .res_valid   (result.valid),
  .res_ready   (result.ready),
  .res_mode    (result.data.mode),
  .res_action  (result.data.action_code),
  .res_cause   (result.data.stop_cause),
  .res_preroll (result.data.preroll_out)
);
